### rtl/kpq_pkg.sv
// Package for the keyed pair quicksort block: sizes, pair and range types,
// and the memory request structs passed between the controller and the top.
// No dependencies.
package kpq_pkg;

  localparam int MAX_PAIRS = 64;
  localparam int IDX_W     = $clog2(MAX_PAIRS);
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int DATA_W    = 16;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] payload;
  } pair_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  localparam int PAIR_W  = $bits(pair_t);
  localparam int RANGE_W = $bits(range_t);

  typedef struct packed {
    logic             ren;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    pair_t            wdata;
  } pair_req_t;

  typedef struct packed {
    logic             ren;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    range_t           wdata;
  } stack_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] count;
  } kpq_status_t;

endpackage

### rtl/kpq_ram.sv
// Generic single-write, single-read memory with registered read data.
// Read returns old data on a same-address write. No dependencies.
module kpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/kpq_ctrl.sv
// Sequencer of the keyed pair quicksort: load, Lomuto partition with one
// shared key comparator, range stack handling and ordered emission.
// Depends on kpq_pkg; drives the pair memory and range stack ports.
module kpq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kpq_pkg::DATA_W-1:0] key,
  input  logic [kpq_pkg::DATA_W-1:0] payload,
  input  logic                       batch_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kpq_pkg::DATA_W-1:0] sorted_key,
  output logic [kpq_pkg::DATA_W-1:0] sorted_payload,
  output logic                       final_pair,
  output logic                       overflowed,
  output kpq_pkg::pair_req_t         pair_req,
  input  kpq_pkg::pair_t             pair_rd,
  output kpq_pkg::stack_req_t        stack_req,
  input  kpq_pkg::range_t            stack_rd,
  output kpq_pkg::kpq_status_t       status
);
  import kpq_pkg::*;

  typedef enum logic [12:0] {
    S_LOAD    = 13'b0000000000001,
    S_POP     = 13'b0000000000010,
    S_POP_W   = 13'b0000000000100,
    S_PIV     = 13'b0000000001000,
    S_SCAN    = 13'b0000000010000,
    S_CMP     = 13'b0000000100000,
    S_FIN_RD  = 13'b0000001000000,
    S_SWP_WA  = 13'b0000010000000,
    S_SWP_WB  = 13'b0000100000000,
    S_PUSH_L  = 13'b0001000000000,
    S_PUSH_H  = 13'b0010000000000,
    S_EMIT_RD = 13'b0100000000000,
    S_EMIT_LD = 13'b1000000000000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [CNT_W-1:0]  depth;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;
  logic              fin;
  logic [DATA_W-1:0] pivot;
  pair_t             hold;

  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  depth_dec;
  logic              out_free;
  logic              emit_go;
  logic              key_less;
  logic              push_lo_ok;
  logic              push_hi_ok;
  logic              emit_last;

  assign in_stall   = (state != S_LOAD);
  assign accept     = in_valid && !in_stall;
  assign room       = (count < CNT_W'(MAX_PAIRS));
  assign count_next = count + CNT_W'(room);
  assign depth_dec  = depth - 1'b1;
  assign out_free   = !out_valid || !out_stall;
  assign emit_go    = (state == S_EMIT_LD) && out_free;
  assign key_less   = (pair_rd.key < pivot);
  assign push_lo_ok = ({1'b0, slot} > ({1'b0, lo} + 1'b1)) && (depth < CNT_W'(MAX_PAIRS));
  assign push_hi_ok = (({1'b0, slot} + 1'b1) < {1'b0, hi}) && (depth < CNT_W'(MAX_PAIRS));
  assign emit_last  = ((CNT_W'(k) + 1'b1) == count);

  assign status.depth = depth;
  assign status.count = count;

  always_comb begin
    pair_req  = '0;
    stack_req = '0;
    case (state)
      S_LOAD: begin
        pair_req.we          = accept && room;
        pair_req.waddr       = count[IDX_W-1:0];
        pair_req.wdata.key     = key;
        pair_req.wdata.payload = payload;
        stack_req.we         = accept && batch_end && (count_next >= CNT_W'(2));
        stack_req.waddr      = '0;
        stack_req.wdata.lo   = '0;
        stack_req.wdata.hi   = IDX_W'(count_next - 1'b1);
      end
      S_POP: begin
        stack_req.ren   = (depth != '0);
        stack_req.raddr = depth_dec[IDX_W-1:0];
      end
      S_POP_W: begin
        pair_req.ren   = 1'b1;
        pair_req.raddr = stack_rd.hi;
      end
      S_SCAN: begin
        pair_req.ren   = 1'b1;
        pair_req.raddr = (j == hi) ? slot : j;
      end
      S_CMP: begin
        pair_req.ren   = key_less;
        pair_req.raddr = slot;
      end
      S_FIN_RD: begin
        pair_req.ren   = 1'b1;
        pair_req.raddr = hi;
      end
      S_SWP_WA: begin
        pair_req.we    = 1'b1;
        pair_req.waddr = a_idx;
        pair_req.wdata = pair_rd;
      end
      S_SWP_WB: begin
        pair_req.we    = 1'b1;
        pair_req.waddr = b_idx;
        pair_req.wdata = hold;
      end
      S_PUSH_L: begin
        stack_req.we       = push_lo_ok;
        stack_req.waddr    = depth[IDX_W-1:0];
        stack_req.wdata.lo = lo;
        stack_req.wdata.hi = slot - 1'b1;
      end
      S_PUSH_H: begin
        stack_req.we       = push_hi_ok;
        stack_req.waddr    = depth[IDX_W-1:0];
        stack_req.wdata.lo = slot + 1'b1;
        stack_req.wdata.hi = hi;
      end
      S_EMIT_RD: begin
        pair_req.ren   = 1'b1;
        pair_req.raddr = k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= count_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (batch_end) begin
              k <= '0;
              if (count_next < CNT_W'(2)) begin
                state <= S_EMIT_RD;
              end else begin
                depth <= CNT_W'(1);
                state <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          if (depth == '0) begin
            state <= S_EMIT_RD;
          end else begin
            depth <= depth_dec;
            state <= S_POP_W;
          end
        end
        S_POP_W: begin
          lo    <= stack_rd.lo;
          hi    <= stack_rd.hi;
          state <= S_PIV;
        end
        S_PIV: begin
          pivot <= pair_rd.key;
          slot  <= lo;
          j     <= lo;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (j == hi) begin
            a_idx <= slot;
            b_idx <= hi;
            fin   <= 1'b1;
            state <= S_FIN_RD;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_less) begin
            hold  <= pair_rd;
            a_idx <= j;
            b_idx <= slot;
            fin   <= 1'b0;
            state <= S_SWP_WA;
          end else begin
            j     <= j + 1'b1;
            state <= S_SCAN;
          end
        end
        S_FIN_RD: begin
          hold  <= pair_rd;
          state <= S_SWP_WA;
        end
        S_SWP_WA: begin
          state <= S_SWP_WB;
        end
        S_SWP_WB: begin
          if (fin) begin
            state <= S_PUSH_L;
          end else begin
            slot  <= slot + 1'b1;
            j     <= j + 1'b1;
            state <= S_SCAN;
          end
        end
        S_PUSH_L: begin
          if (push_lo_ok) begin
            depth <= depth + 1'b1;
          end
          state <= S_PUSH_H;
        end
        S_PUSH_H: begin
          if (push_hi_ok) begin
            depth <= depth + 1'b1;
          end
          state <= S_POP;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            sorted_key     <= pair_rd.key;
            sorted_payload <= pair_rd.payload;
            final_pair     <= emit_last;
            overflowed     <= ovf;
            k              <= k + 1'b1;
            if (emit_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

### rtl/keyed_pair_quicksort.sv
// Top level of the keyed pair quicksort: controller, pair memory, range stack.
// Depends on kpq_pkg, kpq_ram and kpq_ctrl.
//
//  channel | direction | handshake           | fields
//  in      | input     | in_valid / in_stall | key, payload, batch_end
//  out     | output    | out_valid/out_stall | sorted_key, sorted_payload,
//          |           |                     | final_pair, overflowed
//
// Pairs load one per cycle while in_stall is low. After the batch-end transfer,
// each range is popped, its pivot read, pairs below the pivot swapped and the
// sub-ranges pushed; compares and swaps share the single port pair of the pair
// memory. An empty stack ends sorting, then emission reads and loads each pair.
// rst is synchronous and clears control state; memories need no clearing.
// A stall on out holds the result register and, during emission, the sequencer.
module keyed_pair_quicksort (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kpq_pkg::DATA_W-1:0] key,
  input  logic [kpq_pkg::DATA_W-1:0] payload,
  input  logic                       batch_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kpq_pkg::DATA_W-1:0] sorted_key,
  output logic [kpq_pkg::DATA_W-1:0] sorted_payload,
  output logic                       final_pair,
  output logic                       overflowed
);
  import kpq_pkg::*;

  pair_req_t   pair_req;
  pair_t       pair_rd;
  stack_req_t  stack_req;
  range_t      stack_rd;
  kpq_status_t status;

  kpq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .key           (key),
    .payload       (payload),
    .batch_end     (batch_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_key    (sorted_key),
    .sorted_payload(sorted_payload),
    .final_pair    (final_pair),
    .overflowed    (overflowed),
    .pair_req      (pair_req),
    .pair_rd       (pair_rd),
    .stack_req     (stack_req),
    .stack_rd      (stack_rd),
    .status        (status)
  );

  kpq_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(MAX_PAIRS)
  ) u_pair_ram (
    .clk  (clk),
    .we   (pair_req.we),
    .waddr(pair_req.waddr),
    .wdata(pair_req.wdata),
    .ren  (pair_req.ren),
    .raddr(pair_req.raddr),
    .rdata(pair_rd)
  );

  kpq_ram #(
    .WIDTH(RANGE_W),
    .DEPTH(MAX_PAIRS)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_req.we),
    .waddr(stack_req.waddr),
    .wdata(stack_req.wdata),
    .ren  (stack_req.ren),
    .raddr(stack_req.raddr),
    .rdata(stack_rd)
  );

  // busy right after a batch-end transfer
  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && batch_end) |=> in_stall)
    else $error("input taken right after batch end");

  // pending ranges are disjoint and at least two long
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    status.depth <= CNT_W'(MAX_PAIRS / 2))
    else $error("range stack deeper than half the store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(MAX_PAIRS))
    else $error("pair count beyond capacity");

  // stack is empty whenever a batch is being loaded
  a_stack_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (status.depth == '0))
    else $error("ranges pending while loading");

endmodule

### tb/tb_keyed_pair_quicksort.sv
// Self-checking testbench for keyed_pair_quicksort: directed table, then random batches.
// A mirror of the pair store and its Lomuto sort predicts each sorted batch.
// Depends on kpq_pkg and the keyed_pair_quicksort RTL.
`timescale 1ns / 1ps

module tb_keyed_pair_quicksort;
  import kpq_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    logic              last;
    logic              drop;
  } sorted_pair_t;

  typedef struct {
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    logic              last;
    bit                typed;
    sorted_pair_t      want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] key = '0;
  logic [DATA_W-1:0] payload = '0;
  logic              batch_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] sorted_key;
  logic [DATA_W-1:0] sorted_payload;
  logic              final_pair;
  logic              overflowed;

  logic [DATA_W-1:0] mirror_key [MAX_PAIRS];
  logic [DATA_W-1:0] mirror_val [MAX_PAIRS];
  int                mirror_count = 0;
  bit                mirror_drop = 1'b0;

  sorted_pair_t      due_pairs [$];
  stim_row_t         dir_rows [$];
  int                err_count = 0;
  bit                idle_on = 1'b1;
  bit                hold_go = 1'b0;
  bit                hold_req = 1'b0;
  int                stall_left = 0;

  keyed_pair_quicksort u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .key            (key),
    .payload        (payload),
    .batch_end      (batch_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sorted_key     (sorted_key),
    .sorted_payload (sorted_payload),
    .final_pair     (final_pair),
    .overflowed     (overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void swap_slots(int a, int b);
    logic [DATA_W-1:0] t;
    t = mirror_key[a];
    mirror_key[a] = mirror_key[b];
    mirror_key[b] = t;
    t = mirror_val[a];
    mirror_val[a] = mirror_val[b];
    mirror_val[b] = t;
  endfunction

  // Lomuto partition, last element of the span is the pivot
  function automatic int split_span(int lo, int hi);
    logic [DATA_W-1:0] pv;
    int slot;
    pv = mirror_key[hi];
    slot = lo;
    for (int j = lo; j < hi; j++) begin
      if (mirror_key[j] < pv) begin
        swap_slots(slot, j);
        slot++;
      end
    end
    swap_slots(slot, hi);
    return slot;
  endfunction

  function automatic void sort_mirror(int n);
    int span_lo [MAX_PAIRS];
    int span_hi [MAX_PAIRS];
    int depth;
    int lo;
    int hi;
    int p;
    if (n < 2) return;
    span_lo[0] = 0;
    span_hi[0] = n - 1;
    depth = 1;
    while (depth > 0) begin
      depth--;
      lo = span_lo[depth];
      hi = span_hi[depth];
      p = split_span(lo, hi);
      // pivot at the low end leaves an empty left span
      if (p > lo + 1 && depth < MAX_PAIRS) begin
        span_lo[depth] = lo;
        span_hi[depth] = p - 1;
        depth++;
      end
      if (p + 1 < hi && depth < MAX_PAIRS) begin
        span_lo[depth] = p + 1;
        span_hi[depth] = hi;
        depth++;
      end
    end
  endfunction

  function automatic void absorb_pair(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v,
                                      logic last, bit keep);
    sorted_pair_t r;
    if (mirror_count < MAX_PAIRS) begin
      mirror_key[mirror_count] = k;
      mirror_val[mirror_count] = v;
      mirror_count++;
    end else begin
      mirror_drop = 1'b1;
    end
    if (!last) return;
    sort_mirror(mirror_count);
    if (keep) begin
      for (int i = 0; i < mirror_count; i++) begin
        r.k = mirror_key[i];
        r.v = mirror_val[i];
        r.last = (i + 1 == mirror_count);
        r.drop = mirror_drop;
        due_pairs.push_back(r);
      end
    end
    mirror_count = 0;
    mirror_drop = 1'b0;
  endfunction

  function automatic stim_row_t row(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v,
                                    logic last, bit typed);
    stim_row_t s;
    s.k = k;
    s.v = v;
    s.last = last;
    s.typed = typed;
    // a lone pair comes straight back, marked last, nothing dropped
    s.want.k = k;
    s.want.v = v;
    s.want.last = 1'b1;
    s.want.drop = 1'b0;
    return s;
  endfunction

  task automatic send_pair(stim_row_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    key       <= s.k;
    payload   <= s.v;
    batch_end <= s.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_pair(s.k, s.v, s.last, !s.typed);
    if (s.typed) due_pairs.push_back(s.want);
  endtask

  // result side: check each transfer, then pick the next stall value
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_pairs.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result key=%h payload=%h final=%b ovf=%b",
                     sorted_key, sorted_payload, final_pair, overflowed);
          err_count++;
        end else begin
          if (sorted_key !== due_pairs[0].k || sorted_payload !== due_pairs[0].v ||
              final_pair !== due_pairs[0].last || overflowed !== due_pairs[0].drop) begin
            if (err_count < 10)
              $display("mismatch: exp key=%h payload=%h final=%b ovf=%b,",
                       due_pairs[0].k, due_pairs[0].v, due_pairs[0].last, due_pairs[0].drop,
                       " got key=%h payload=%h final=%b ovf=%b",
                       sorted_key, sorted_payload, final_pair, overflowed);
            err_count++;
          end
          void'(due_pairs.pop_front());
        end
      end
      if (hold_req) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(negedge clk) hold_req = 1'b1;
    repeat (400) @(negedge clk);
    hold_req = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("keyed_pair_quicksort test failed");
    $finish;
  end

  initial begin
    int sent;
    int bno;
    int size;
    int mode;
    logic [DATA_W-1:0] base;
    stim_row_t s;

    dir_rows.push_back(row(16'h0000, 16'h0000, 1'b1, 1'b1));
    dir_rows.push_back(row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    dir_rows.push_back(row(16'hFFFF, 16'h0000, 1'b1, 1'b1));
    dir_rows.push_back(row(16'h0000, 16'hFFFF, 1'b1, 1'b1));
    // descending keys: pivot lands at the low end
    dir_rows.push_back(row(16'h0004, 16'h0A01, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0003, 16'h0A02, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0002, 16'h0A03, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0001, 16'h0A04, 1'b1, 1'b0));
    // ascending keys: pivot stays at the high end
    dir_rows.push_back(row(16'h0001, 16'h0B01, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0002, 16'h0B02, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0003, 16'h0B03, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0004, 16'h0B04, 1'b1, 1'b0));
    // equal keys
    dir_rows.push_back(row(16'h0007, 16'h0001, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0007, 16'h0002, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0007, 16'h0003, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0007, 16'h0004, 1'b1, 1'b0));
    dir_rows.push_back(row(16'hFFFF, 16'h1234, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0000, 16'h5678, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h8000, 16'hAAAA, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h7FFF, 16'h5555, 1'b0, 1'b0));
    dir_rows.push_back(row(16'h0000, 16'h0F0F, 1'b1, 1'b0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_pair(dir_rows[i]);

    hold_go = 1'b1;
    sent = 0;
    bno = 0;
    while (sent < 240) begin
      if (bno == 4) size = MAX_PAIRS;
      else if (bno == 9) size = MAX_PAIRS + 2;   // store full, end pair dropped
      else if ($urandom_range(0, 19) == 0) size = $urandom_range(20, MAX_PAIRS);
      else size = $urandom_range(1, 10);
      mode = $urandom_range(0, 3);
      base = DATA_W'($urandom);
      if (240 - sent < 40) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < size; i++) begin
        case (mode)
          0: s.k = DATA_W'($urandom);
          1: s.k = DATA_W'($urandom_range(0, 3));
          2: s.k = base + i[DATA_W-1:0];
          default: s.k = base - i[DATA_W-1:0];
        endcase
        s.v = DATA_W'($urandom);
        s.last = (i == size - 1);
        s.typed = 1'b0;
        send_pair(s);
      end
      sent += size;
      bno++;
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    while (due_pairs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("keyed_pair_quicksort test passed");
    end else begin
      $display("keyed_pair_quicksort test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/kpq_pkg.sv
rtl/kpq_ram.sv
rtl/kpq_ctrl.sv
rtl/keyed_pair_quicksort.sv
tb/tb_keyed_pair_quicksort.sv
